[rtl/core/mms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants of the min/max stack
// Sizes, beat types, operation and status codes, RAM port bundle.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int unsigned DEPTH      = 4096;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(DEPTH);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             count_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_RUN  = 1'b0,
    S_FILL = 1'b1
  } state_t;

  typedef struct packed {
    op_t   operation;
    data_t value;
  } cmd_t;

  typedef struct packed {
    data_t   popped_value;
    data_t   current_min;
    data_t   current_max;
    logic    is_empty;
    status_t status;
  } res_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    data_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } ram_req_t;

endpackage

[rtl/core/mms_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module mms_ram
  import mms_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output data_t    rd_data
);

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/core/min_max_stack_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_stack_top: bounded signed stack with running minimum and maximum
// Value, min and max stacks live in RAM; their tops are cached in registers.
//
//   channel | signals                      | direction | beat
//   cmd     | cmd_valid, cmd_stall, cmd    | in        | operation, value
//   res     | res_valid, res_stall, res    | out       | popped value, min, max,
//           |                              |           | empty flag, status
//
// A push, or a rejected push or pop, registers its result at the accepting
// edge. A pop first reads the new tops of the three RAMs, then, once the
// output register is free, loads them and registers the result.
// Reset empties all three stacks at once; RAM contents are not cleared.
// A stalled result holds in the output register; a new beat is taken only
// when that register is free or being drained.
// ----------------------------------------------------------------------------
module min_max_stack_top
  import mms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  state_t   state, state_next;
  count_t   value_count, value_count_next;
  count_t   min_count, min_count_next;
  count_t   max_count, max_count_next;
  data_t    val_top, val_top_next;
  data_t    min_top, min_top_next;
  data_t    max_top, max_top_next;
  res_t     res_next;
  logic     res_load;
  logic     res_free;
  logic     accept;
  logic     push_min;
  logic     push_max;
  logic     pop_min;
  logic     pop_max;
  count_t   val_rd_ptr;
  count_t   min_rd_ptr;
  count_t   max_rd_ptr;
  ram_req_t val_req, min_req, max_req;
  data_t    val_rd, min_rd, max_rd;

  mms_ram u_val_ram (.clk(clk), .req(val_req), .rd_data(val_rd));
  mms_ram u_min_ram (.clk(clk), .req(min_req), .rd_data(min_rd));
  mms_ram u_max_ram (.clk(clk), .req(max_req), .rd_data(max_rd));

  assign res_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != S_RUN) || !res_free;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    state_next       = state;
    value_count_next = value_count;
    min_count_next   = min_count;
    max_count_next   = max_count;
    val_top_next     = val_top;
    min_top_next     = min_top;
    max_top_next     = max_top;
    res_next         = res;
    res_load         = 1'b0;
    push_min         = 1'b0;
    push_max         = 1'b0;
    pop_min          = 1'b0;
    pop_max          = 1'b0;
    val_rd_ptr       = '0;
    min_rd_ptr       = '0;
    max_rd_ptr       = '0;
    val_req          = '0;
    min_req          = '0;
    max_req          = '0;

    unique case (state)
      S_RUN: begin
        if (accept) begin
          unique case (cmd.operation)
            OP_PUSH: begin
              if (value_count == CNT_W'(DEPTH)) begin
                res_load              = 1'b1;
                res_next.popped_value = '0;
                res_next.current_min  = min_top;
                res_next.current_max  = max_top;
                res_next.is_empty     = 1'b0;
                res_next.status       = ST_FULL;
              end else begin
                push_min = (min_count == '0) || (cmd.value <= min_top);
                push_max = (max_count == '0) || (cmd.value >= max_top);
                val_req.wr_en    = 1'b1;
                val_req.wr_addr  = value_count[ADDR_W-1:0];
                val_req.wr_data  = cmd.value;
                value_count_next = value_count + CNT_W'(1);
                val_top_next     = cmd.value;
                if (push_min && (min_count != CNT_W'(DEPTH))) begin
                  min_req.wr_en   = 1'b1;
                  min_req.wr_addr = min_count[ADDR_W-1:0];
                  min_req.wr_data = cmd.value;
                  min_count_next  = min_count + CNT_W'(1);
                  min_top_next    = cmd.value;
                end
                if (push_max && (max_count != CNT_W'(DEPTH))) begin
                  max_req.wr_en   = 1'b1;
                  max_req.wr_addr = max_count[ADDR_W-1:0];
                  max_req.wr_data = cmd.value;
                  max_count_next  = max_count + CNT_W'(1);
                  max_top_next    = cmd.value;
                end
                res_load              = 1'b1;
                res_next.popped_value = '0;
                res_next.current_min  = min_top_next;
                res_next.current_max  = max_top_next;
                res_next.is_empty     = 1'b0;
                res_next.status       = ST_OK;
              end
            end
            OP_POP: begin
              if (value_count == '0) begin
                res_load              = 1'b1;
                res_next.popped_value = '0;
                res_next.current_min  = '0;
                res_next.current_max  = '0;
                res_next.is_empty     = 1'b1;
                res_next.status       = ST_EMPTY;
              end else begin
                pop_min = (min_count != '0) && (val_top == min_top);
                pop_max = (max_count != '0) && (val_top == max_top);
                value_count_next = value_count - CNT_W'(1);
                if (pop_min) begin
                  min_count_next = min_count - CNT_W'(1);
                end
                if (pop_max) begin
                  max_count_next = max_count - CNT_W'(1);
                end
                // fetch the tops left behind
                val_rd_ptr      = value_count_next - CNT_W'(1);
                min_rd_ptr      = min_count_next - CNT_W'(1);
                max_rd_ptr      = max_count_next - CNT_W'(1);
                val_req.rd_en   = 1'b1;
                val_req.rd_addr = val_rd_ptr[ADDR_W-1:0];
                min_req.rd_en   = 1'b1;
                min_req.rd_addr = min_rd_ptr[ADDR_W-1:0];
                max_req.rd_en   = 1'b1;
                max_req.rd_addr = max_rd_ptr[ADDR_W-1:0];
                state_next      = S_FILL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        if (res_free) begin
          val_top_next          = val_rd;
          min_top_next          = min_rd;
          max_top_next          = max_rd;
          res_load              = 1'b1;
          res_next.popped_value = val_top;
          res_next.current_min  = (value_count != '0) ? min_rd : '0;
          res_next.current_max  = (value_count != '0) ? max_rd : '0;
          res_next.is_empty     = (value_count == '0);
          res_next.status       = ST_OK;
          state_next            = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      value_count <= '0;
      min_count   <= '0;
      max_count   <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      value_count <= value_count_next;
      min_count   <= min_count_next;
      max_count   <= max_count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_top <= val_top_next;
    min_top <= min_top_next;
    max_top <= max_top_next;
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule
